### src/ptrs_pkg.sv
// ptrs_pkg: shared types and constants for the periodic task release scheduler
// no dependencies; imported by ptrs_slot_alu and periodic_task_release_scheduler
`timescale 1ns / 1ps
`default_nettype none

package ptrs_pkg;

  localparam int unsigned NUM_TASKS = 8;
  localparam int unsigned IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned PEND_W    = 8;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned TSLOT_W   = 3;

  localparam logic [PEND_W-1:0] PEND_MAX = '1;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_DISPATCH = 2'd1,
    ACT_ADD      = 2'd2,
    ACT_ENABLE   = 2'd3
  } action_e;

  typedef struct packed {
    logic                valid;
    logic                en;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] cd;
    logic [PEND_W-1:0]   pend;
  } slot_rec_t;

endpackage

`default_nettype wire

### src/ptrs_slot_alu.sv
// ptrs_slot_alu: shared update unit applied to one task slot per cycle
// depends on ptrs_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptrs_slot_alu (
  input  ptrs_pkg::action_e                  act_i,
  input  ptrs_pkg::slot_rec_t                rec_i,
  input  logic [ptrs_pkg::PERIOD_W-1:0]      period_i,
  input  logic                               enable_i,
  output ptrs_pkg::slot_rec_t                rec_o,
  output logic                               hit_o
);
  import ptrs_pkg::*;

  logic [PERIOD_W-1:0] cd_dec;

  assign cd_dec = rec_i.cd - PERIOD_W'(1);

  always_comb begin
    rec_o = rec_i;
    hit_o = 1'b0;
    unique case (act_i)
      ACT_TICK: begin
        if (rec_i.valid && rec_i.en && (rec_i.cd != '0)) begin
          if (cd_dec == '0) begin
            rec_o.cd = rec_i.period;
            if (rec_i.pend != PEND_MAX) begin
              rec_o.pend = rec_i.pend + PEND_W'(1);
            end
          end else begin
            rec_o.cd = cd_dec;
          end
        end
      end
      ACT_DISPATCH: begin
        if (rec_i.valid && rec_i.en && (rec_i.pend != '0)) begin
          hit_o      = 1'b1;
          rec_o.pend = rec_i.pend - PEND_W'(1);
        end
      end
      ACT_ADD: begin
        rec_o.valid  = 1'b1;
        rec_o.en     = 1'b1;
        rec_o.period = period_i;
        rec_o.cd     = period_i;
        rec_o.pend   = PEND_W'(1);
      end
      ACT_ENABLE: begin
        rec_o.en = enable_i;
      end
      default: begin
        rec_o = rec_i;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/periodic_task_release_scheduler.sv
// periodic_task_release_scheduler: slot table, scan sequencer and result register
// depends on ptrs_pkg and ptrs_slot_alu
//
// usage:
//   input channel (in_valid_i / in_ready_o) carries one word per request:
//   action_i (tick, dispatch, add, set enable), slot_i, period_i, enable_i.
//   output channel (out_valid_o / out_ready_i) returns exactly one word per
//   request: dispatched_o, task_slot_o, accepted_o, tick_count_o.
//   a single update unit visits the slot table one slot per cycle.
//   tick walks all NUM_TASKS slots; dispatch walks until the first ready slot
//   or the table's end; add and set enable touch only the addressed slot.
//   a request passes from the idle state through the scan state to the done
//   state, which loads the output register (out-of-range add/enable skips
//   the scan); in_ready_o rises in the same cycle as out_valid_o.
//   one request is in flight at a time; the next is taken once the result sits
//   in the output register, so a stalled receiver holds at most one word and
//   blocks further requests only when a second result is ready.
//   reset clears the table, tick counter and out_valid_o, and leaves in_ready_o high.
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_release_scheduler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        action_i,
  input  logic [ptrs_pkg::SLOT_W-1:0]       slot_i,
  input  logic [ptrs_pkg::PERIOD_W-1:0]     period_i,
  input  logic                              enable_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              dispatched_o,
  output logic [ptrs_pkg::TSLOT_W-1:0]      task_slot_o,
  output logic                              accepted_o,
  output logic [ptrs_pkg::TICK_W-1:0]       tick_count_o
);
  import ptrs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e              state_q;
  action_e             act_q;
  logic [PERIOD_W-1:0] per_q;
  logic                ena_q;
  logic [IDX_W-1:0]    idx_q;
  logic [TICK_W-1:0]   tick_cnt_q;
  logic                res_disp_q;
  logic [TSLOT_W-1:0]  res_slot_q;
  logic                res_acc_q;

  logic                out_valid_q;
  logic                out_disp_q;
  logic [TSLOT_W-1:0]  out_slot_q;
  logic                out_acc_q;
  logic [TICK_W-1:0]   out_tick_q;

  logic                valid_q  [NUM_TASKS];
  logic                en_q     [NUM_TASKS];
  logic [PERIOD_W-1:0] period_q [NUM_TASKS];
  logic [PERIOD_W-1:0] cd_q     [NUM_TASKS];
  logic [PEND_W-1:0]   pend_q   [NUM_TASKS];

  slot_rec_t           rec_rd;
  slot_rec_t           rec_wr;
  logic                hit;
  logic                in_fire;
  logic                last;
  logic                in_range;
  logic                tbl_we;
  logic [SLOT_W-1:0]   idx_ext;
  action_e             act_in;

  assign act_in   = action_e'(action_i);
  assign in_fire  = in_valid_i && in_ready_o;
  assign in_range = (slot_i < SLOT_W'(NUM_TASKS));
  assign last     = (idx_q == IDX_W'(NUM_TASKS - 1));
  assign idx_ext  = SLOT_W'(idx_q);
  assign tbl_we   = (state_q == S_SCAN);

  assign rec_rd.valid  = valid_q[idx_q];
  assign rec_rd.en     = en_q[idx_q];
  assign rec_rd.period = period_q[idx_q];
  assign rec_rd.cd     = cd_q[idx_q];
  assign rec_rd.pend   = pend_q[idx_q];

  ptrs_slot_alu u_alu (
    .act_i    (act_q),
    .rec_i    (rec_rd),
    .period_i (per_q),
    .enable_i (ena_q),
    .rec_o    (rec_wr),
    .hit_o    (hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        valid_q[i]  <= 1'b0;
        en_q[i]     <= 1'b0;
        period_q[i] <= '0;
        cd_q[i]     <= '0;
        pend_q[i]   <= '0;
      end
    end else if (tbl_we) begin
      valid_q[idx_q]  <= rec_wr.valid;
      en_q[idx_q]     <= rec_wr.en;
      period_q[idx_q] <= rec_wr.period;
      cd_q[idx_q]     <= rec_wr.cd;
      pend_q[idx_q]   <= rec_wr.pend;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_TICK;
      per_q       <= '0;
      ena_q       <= 1'b0;
      idx_q       <= '0;
      tick_cnt_q  <= '0;
      res_disp_q  <= 1'b0;
      res_slot_q  <= '0;
      res_acc_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_disp_q  <= 1'b0;
      out_slot_q  <= '0;
      out_acc_q   <= 1'b0;
      out_tick_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            act_q      <= act_in;
            per_q      <= period_i;
            ena_q      <= enable_i;
            res_disp_q <= 1'b0;
            res_slot_q <= '0;
            res_acc_q  <= 1'b0;
            if (act_in == ACT_TICK) begin
              tick_cnt_q <= tick_cnt_q + TICK_W'(1);
            end
            if (act_in == ACT_ADD || act_in == ACT_ENABLE) begin
              idx_q   <= slot_i[IDX_W-1:0];
              state_q <= in_range ? S_SCAN : S_DONE;
            end else begin
              idx_q   <= '0;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (act_q == ACT_ADD || act_q == ACT_ENABLE) begin
            res_acc_q <= (act_q == ACT_ADD);
            state_q   <= S_DONE;
          end else if (act_q == ACT_DISPATCH && hit) begin
            res_disp_q <= 1'b1;
            res_slot_q <= idx_ext[TSLOT_W-1:0];
            state_q    <= S_DONE;
          end else if (last) begin
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_disp_q  <= res_disp_q;
            out_slot_q  <= res_slot_q;
            out_acc_q   <= res_acc_q;
            out_tick_q  <= tick_cnt_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dispatched_o = out_disp_q;
  assign task_slot_o  = out_slot_q;
  assign accepted_o   = out_acc_q;
  assign tick_count_o = out_tick_q;

  // busy after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("request taken while busy");

  // a word never reports both a dispatch and an accepted add
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(dispatched_o && accepted_o))
    else $error("dispatch and add flags both set");

  // scan index stays inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= IDX_W'(NUM_TASKS - 1)))
    else $error("scan index out of range");

  // tick counter moves by one on every tick request and only then
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && act_in == ACT_TICK) |=> (tick_cnt_q == $past(tick_cnt_q) + TICK_W'(1)))
    else $error("tick counter did not advance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && act_in == ACT_TICK) |=> $stable(tick_cnt_q))
    else $error("tick counter moved without a tick");

endmodule

`default_nettype wire
